>>> rtl/necir_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR transmitter package
// Shared types, register indexes and reset values for the NEC IR frame
// transmitter.
// ----------------------------------------------------------------------------
package necir_pkg;

  // Width of the phase tick counter and of the duration registers.
  localparam int CntW = 16;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_LEAD_MARK  = 3'd0,
    REG_LEAD_SPACE = 3'd1,
    REG_BIT_MARK   = 3'd2,
    REG_ONE_SPACE  = 3'd3,
    REG_ZERO_SPACE = 3'd4,
    REG_ADDR_FIRST = 3'd5,
    REG_ADDR_SECOND = 3'd6
  } reg_index_t;

  // Register reset values.
  localparam logic [CntW-1:0] RstLeadMark  = CntW'(223);
  localparam logic [CntW-1:0] RstLeadSpace = CntW'(117);
  localparam logic [CntW-1:0] RstBitMark   = CntW'(10);
  localparam logic [CntW-1:0] RstOneSpace  = CntW'(41);
  localparam logic [CntW-1:0] RstZeroSpace = CntW'(15);
  localparam logic [7:0]      RstAddrFirst = 8'd3;
  localparam logic [7:0]      RstAddrSecond = 8'd252;

  // Kind of an item after classification by the front end.
  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_START = 1'b1
  } item_kind_t;

  // One queued item.
  typedef struct packed {
    item_kind_t kind;
    logic [7:0] data_byte;
  } queue_item_t;

  // Configuration as seen by the engine.
  typedef struct packed {
    logic [CntW-1:0] leader_mark_ticks;
    logic [CntW-1:0] leader_space_ticks;
    logic [CntW-1:0] bit_mark_ticks;
    logic [CntW-1:0] one_space_ticks;
    logic [CntW-1:0] zero_space_ticks;
    logic [7:0]      address_first_byte;
    logic [7:0]      address_second_byte;
  } cfg_t;

  // A duration of zero behaves like one tick.
  function automatic logic [CntW-1:0] eff_duration(input logic [CntW-1:0] r);
    logic [CntW-1:0] d;
    d = (r == '0) ? CntW'(1) : r;
    return d;
  endfunction

endpackage

>>> rtl/necir_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR front end
// Accepts stream items, classifies them as ticks or start commands and
// places them in a two-entry queue toward the frame engine.
// ----------------------------------------------------------------------------
module necir_front
  import necir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] cmd
  output logic        q_valid,
  input  logic        q_ready,
  output queue_item_t q_item
);

  queue_item_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;
  queue_item_t in_item;

  // Classify the incoming item.
  always_comb begin
    in_item.kind      = s_tuser[0] ? KIND_START : KIND_TICK;
    in_item.data_byte = s_tdata;
  end

  assign s_tready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign push     = s_tvalid && s_tready;
  assign pop      = q_valid && q_ready;
  assign q_item   = entries[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_item;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> rtl/necir_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR frame engine
// Steps the frame sequencer once per queued item and holds the result item
// in an output register.
// ----------------------------------------------------------------------------
module necir_engine
  import necir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        q_valid,
  output logic        q_ready,
  input  queue_item_t q_item,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] ir_level, [1] busy_res
  output logic        m_tlast    // frame_done
);

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_LEAD_MARK  = 3'd1,
    PH_LEAD_SPACE = 3'd2,
    PH_BIT_MARK   = 3'd3,
    PH_BIT_SPACE  = 3'd4,
    PH_TRAIL      = 3'd5
  } phase_t;

  phase_t          phase, phase_next;
  logic [CntW-1:0] tick_count, tick_count_next;
  logic [4:0]      bit_index, bit_index_next;
  logic [31:0]     frame_shift, frame_shift_next;
  logic            carrier_level, carrier_level_next;
  logic            done_next;
  logic            take;
  logic            in_mark;
  logic [CntW-1:0] dur;
  logic [CntW-1:0] cnt_inc;
  logic            res_level, res_busy, res_done;

  assign q_ready = !m_tvalid || m_tready;
  assign take    = q_valid && q_ready;
  assign cnt_inc = tick_count + CntW'(1);
  assign in_mark = (phase == PH_LEAD_MARK) || (phase == PH_BIT_MARK) || (phase == PH_TRAIL);
  assign m_tdata = {6'd0, res_busy, res_level};
  assign m_tlast = res_done;

  // Duration of the current phase.
  always_comb begin
    case (phase)
      PH_LEAD_MARK:  dur = eff_duration(cfg.leader_mark_ticks);
      PH_LEAD_SPACE: dur = eff_duration(cfg.leader_space_ticks);
      PH_BIT_MARK:   dur = eff_duration(cfg.bit_mark_ticks);
      PH_BIT_SPACE:  dur = frame_shift[0] ? eff_duration(cfg.one_space_ticks)
                                          : eff_duration(cfg.zero_space_ticks);
      PH_TRAIL:      dur = eff_duration(cfg.bit_mark_ticks);
      default:       dur = '0;
    endcase
  end

  // Next sequencer state for the item at the head of the queue.
  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    bit_index_next     = bit_index;
    frame_shift_next   = frame_shift;
    carrier_level_next = carrier_level;
    done_next          = 1'b0;
    if (q_item.kind == KIND_START) begin
      // A start while a frame runs is dropped.
      if (phase == PH_IDLE) begin
        frame_shift_next   = {~q_item.data_byte, q_item.data_byte,
                              cfg.address_second_byte, cfg.address_first_byte};
        phase_next         = PH_LEAD_MARK;
        tick_count_next    = '0;
        bit_index_next     = 5'd0;
        carrier_level_next = 1'b0;
      end
    end else begin
      carrier_level_next = in_mark ? ~carrier_level : 1'b0;
      case (phase)
        PH_LEAD_MARK, PH_LEAD_SPACE, PH_BIT_MARK, PH_BIT_SPACE, PH_TRAIL: begin
          tick_count_next = cnt_inc;
          if (cnt_inc >= dur) begin
            tick_count_next = '0;
            case (phase)
              PH_LEAD_MARK:  phase_next = PH_LEAD_SPACE;
              PH_LEAD_SPACE: phase_next = PH_BIT_MARK;
              PH_BIT_MARK:   phase_next = PH_BIT_SPACE;
              PH_BIT_SPACE: begin
                frame_shift_next = {1'b0, frame_shift[31:1]};
                if (bit_index == 5'd31) begin
                  bit_index_next = 5'd0;
                  phase_next     = PH_TRAIL;
                end else begin
                  bit_index_next = bit_index + 5'd1;
                  phase_next     = PH_BIT_MARK;
                end
              end
              default: begin
                phase_next = PH_IDLE;
                done_next  = 1'b1;
              end
            endcase
          end
        end
        default: begin
          phase_next      = PH_IDLE;
          tick_count_next = '0;
        end
      endcase
    end
  end

  // Sequencer state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_count    <= '0;
      bit_index     <= 5'd0;
      frame_shift   <= '0;
      carrier_level <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (take) begin
        phase         <= phase_next;
        tick_count    <= tick_count_next;
        bit_index     <= bit_index_next;
        frame_shift   <= frame_shift_next;
        carrier_level <= carrier_level_next;
        res_level     <= carrier_level_next;
        res_busy      <= (phase_next != PH_IDLE);
        res_done      <= done_next;
        m_tvalid      <= 1'b1;
      end else if (m_tready) begin
        m_tvalid      <= 1'b0;
      end
    end
  end

  // The bit counter only moves while data bits are on the air.
  a_bit_index_quiet: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE || phase == PH_LEAD_MARK || phase == PH_LEAD_SPACE ||
     phase == PH_TRAIL) |-> (bit_index == 5'd0))
    else $error("bit index moved outside the data bits");

  // The tick counter rests at zero while idle.
  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_IDLE) |-> (tick_count == '0))
    else $error("tick counter nonzero while idle");

  // A result that ends a frame never reports busy.
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res_done) |-> !res_busy)
    else $error("frame done reported while busy");

  // Finishing a frame leaves the sequencer idle.
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    (take && done_next) |=> (phase == PH_IDLE))
    else $error("sequencer not idle after frame end");

endmodule

>>> rtl/nec_ir_frame_transmitter_unit.sv
`timescale 1ns / 1ps
// A result item is held first in a front-queue entry, then in the engine's
// output register. Throughput: one item per cycle unless m_tready stalls;
// the engine retires one queued item every cycle while its output can move.
// Reset (rst, synchronous): sequencer idle, queue and output empty, emitter low,
// configuration registers return to their default NEC timing and address.
// ----------------------------------------------------------------------------
// NEC IR frame transmitter
// Top level: configuration registers, front-end queue and frame engine.
// ----------------------------------------------------------------------------
module nec_ir_frame_transmitter_unit
  import necir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic [0:0]  s_tuser,    // [0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [0] ir_level, [1] busy_res
  output logic        m_tlast,    // frame_done
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t        cfg;
  logic        q_valid;
  logic        q_ready;
  queue_item_t q_item;
  logic        cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Configuration register file; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.leader_mark_ticks   <= RstLeadMark;
      cfg.leader_space_ticks  <= RstLeadSpace;
      cfg.bit_mark_ticks      <= RstBitMark;
      cfg.one_space_ticks     <= RstOneSpace;
      cfg.zero_space_ticks    <= RstZeroSpace;
      cfg.address_first_byte  <= RstAddrFirst;
      cfg.address_second_byte <= RstAddrSecond;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_LEAD_MARK:   cfg.leader_mark_ticks   <= cfg_data;
        REG_LEAD_SPACE:  cfg.leader_space_ticks  <= cfg_data;
        REG_BIT_MARK:    cfg.bit_mark_ticks      <= cfg_data;
        REG_ONE_SPACE:   cfg.one_space_ticks     <= cfg_data;
        REG_ZERO_SPACE:  cfg.zero_space_ticks    <= cfg_data;
        REG_ADDR_FIRST:  cfg.address_first_byte  <= cfg_data[7:0];
        REG_ADDR_SECOND: cfg.address_second_byte <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Front end: accept and classify items.
  necir_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // Back end: frame sequencer and result register.
  necir_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

>>> verif/nec_ir_frame_transmitter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR transmitter checker
// Watches the item, result and configuration channels of the transmitter,
// keeps its own copy of the frame sequencer and the timing registers, and
// compares every result item with the emitter state that the sequencer
// predicts for the input item that caused it.
// ----------------------------------------------------------------------------
module nec_ir_frame_transmitter_checker
  import necir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] data_byte
  input  logic [0:0]  s_tuser,    // [0] cmd
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,    // [0] ir_level, [1] busy_res
  input  logic        m_tlast,    // frame_done
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending
);

  // Sequencer phases of the frame.
  typedef enum logic [2:0] {
    TX_IDLE,
    TX_LEAD_MARK,
    TX_LEAD_SPACE,
    TX_BIT_MARK,
    TX_BIT_SPACE,
    TX_TRAIL
  } tx_phase_t;

  // Result as it appears on m_tlast and m_tdata.
  typedef struct packed {
    logic       frame_done;
    logic [5:0] pad;
    logic       busy;
    logic       level;
  } emitter_word_t;

  cfg_t            timing;
  tx_phase_t       phase_q;
  logic [CntW-1:0] tick_cnt;
  logic [4:0]      bit_idx;
  logic [31:0]     frame_bits;
  logic            level_q;
  emitter_word_t   emitter_q[$];
  int              err_cnt = 0;

  // Register write as the block sees it; unknown indexes change nothing.
  task automatic write_timing(input logic [2:0] idx, input logic [15:0] v);
    case (idx)
      REG_LEAD_MARK:   timing.leader_mark_ticks = v;
      REG_LEAD_SPACE:  timing.leader_space_ticks = v;
      REG_BIT_MARK:    timing.bit_mark_ticks = v;
      REG_ONE_SPACE:   timing.one_space_ticks = v;
      REG_ZERO_SPACE:  timing.zero_space_ticks = v;
      REG_ADDR_FIRST:  timing.address_first_byte = v[7:0];
      REG_ADDR_SECOND: timing.address_second_byte = v[7:0];
      default: ;
    endcase
  endtask

  // Advance the frame sequencer by one item and form the emitter state after it.
  task automatic step_frame(input logic cmd, input logic [7:0] data,
                            output emitter_word_t r);
    logic [CntW-1:0] span;
    logic            done;
    done = 1'b0;
    if (cmd == KIND_START) begin
      // A start is taken only while idle; it latches the whole 32-bit frame.
      if (phase_q == TX_IDLE) begin
        frame_bits = {~data, data, timing.address_second_byte, timing.address_first_byte};
        phase_q    = TX_LEAD_MARK;
        tick_cnt   = '0;
        bit_idx    = '0;
        level_q    = 1'b0;
      end
    end else begin
      // Carrier toggles in marks and is held low otherwise.
      if (phase_q == TX_LEAD_MARK || phase_q == TX_BIT_MARK || phase_q == TX_TRAIL) begin
        level_q = ~level_q;
      end else begin
        level_q = 1'b0;
      end
      case (phase_q)
        TX_LEAD_MARK:          span = timing.leader_mark_ticks;
        TX_LEAD_SPACE:         span = timing.leader_space_ticks;
        TX_BIT_MARK, TX_TRAIL: span = timing.bit_mark_ticks;
        TX_BIT_SPACE: begin
          span = frame_bits[0] ? timing.one_space_ticks : timing.zero_space_ticks;
        end
        default:               span = '0;
      endcase
      // A zero length lasts one tick.
      if (span == '0) span = CntW'(1);
      if (phase_q != TX_IDLE) begin
        tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= span) begin
          tick_cnt = '0;
          case (phase_q)
            TX_LEAD_MARK:  phase_q = TX_LEAD_SPACE;
            TX_LEAD_SPACE: phase_q = TX_BIT_MARK;
            TX_BIT_MARK:   phase_q = TX_BIT_SPACE;
            TX_BIT_SPACE: begin
              frame_bits = frame_bits >> 1;
              if (bit_idx == 5'd31) begin
                bit_idx = '0;
                phase_q = TX_TRAIL;
              end else begin
                bit_idx = bit_idx + 1'b1;
                phase_q = TX_BIT_MARK;
              end
            end
            default: begin
              phase_q = TX_IDLE;
              done    = 1'b1;
            end
          endcase
        end
      end else begin
        tick_cnt = '0;
      end
    end
    r = '{frame_done: done, pad: '0, busy: (phase_q != TX_IDLE), level: level_q};
  endtask

  task automatic report(input string field, input logic [7:0] want, input logic [7:0] got);
    err_cnt++;
    $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
  endtask

  // Channel monitor: results are matched before new items are predicted.
  always @(posedge clk) begin : watch
    emitter_word_t want;
    emitter_word_t got;
    if (rst) begin
      timing = '{leader_mark_ticks: RstLeadMark, leader_space_ticks: RstLeadSpace,
                 bit_mark_ticks: RstBitMark, one_space_ticks: RstOneSpace,
                 zero_space_ticks: RstZeroSpace, address_first_byte: RstAddrFirst,
                 address_second_byte: RstAddrSecond};
      phase_q    = TX_IDLE;
      tick_cnt   = '0;
      bit_idx    = '0;
      frame_bits = '0;
      level_q    = 1'b0;
      emitter_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tlast, m_tdata};
        if (emitter_q.size() == 0) begin
          err_cnt++;
          $display("%0t ns: result item with nothing expected, expected none, actual %0h",
                   $time, got);
        end else begin
          want = emitter_q.pop_front();
          if (got.level !== want.level) begin
            report("ir_level", 8'(want.level), 8'(got.level));
          end
          if (got.busy !== want.busy) begin
            report("busy_res", 8'(want.busy), 8'(got.busy));
          end
          if (got.frame_done !== want.frame_done) begin
            report("frame_done", 8'(want.frame_done), 8'(got.frame_done));
          end
          if (got.pad !== want.pad) report("padding", 8'(want.pad), 8'(got.pad));
        end
      end
      if (cfg_valid && cfg_ready) write_timing(cfg_index, cfg_data);
      if (s_tvalid && s_tready) begin
        step_frame(s_tuser[0], s_tdata, want);
        emitter_q.push_back(want);
      end
    end
    errors  <= err_cnt;
    pending <= emitter_q.size();
  end

endmodule

>>> verif/nec_ir_frame_transmitter_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// NEC IR transmitter testbench
// Drives tick and start items under a series of timing and address settings,
// with bursty input, a stalling result side and long result hold-offs,
// and reports the verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module nec_ir_frame_transmitter_unit_tb;
  import necir_pkg::*;

  localparam logic [2:0] RegNone = 3'd7;
  localparam int IdleLimit  = 5000;
  localparam int HoldCycles = 80;
  localparam int TailCycles = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // [7:0] data_byte
  logic [0:0]  s_tuser = '0;     // [0] cmd
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;          // [0] ir_level, [1] busy_res
  logic        m_tlast;          // frame_done
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  int          errors;
  int          pending;
  int          idle_cycles = 0;

  always #1 clk = ~clk;

  nec_ir_frame_transmitter_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  nec_ir_frame_transmitter_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  // Watchdog: the run ends if no channel moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a long hold-off, then varied stall segments with rare hold-offs.
  initial begin : drain
    int mode;
    int seg;
    while (rst) @(posedge clk);
    m_tready <= 1'b0;
    repeat (HoldCycles) @(posedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(16, 160);
      for (int n = 0; n < seg; n++) begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ((n % 4) != 3);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
      if ($urandom_range(0, 29) == 0) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
    end
  end

  // Offer one item and wait until it is taken.
  task automatic send_item(input item_kind_t kind, input logic [7:0] data);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  // Random items in bursts; starts are rare so that frames run their course.
  task automatic run_items(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) begin
        send_item(($urandom_range(0, 15) == 0) ? KIND_START : KIND_TICK,
                  8'($urandom_range(0, 255)));
      end
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0 && left > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Wait until every result is out, then load a complete register set.
  task automatic load_timing(input logic [15:0] lead_mark, input logic [15:0] lead_space,
                             input logic [15:0] bit_mark, input logic [15:0] one_space,
                             input logic [15:0] zero_space, input logic [15:0] addr_a,
                             input logic [15:0] addr_b);
    do @(posedge clk); while (pending != 0);
    write_reg(REG_LEAD_MARK, lead_mark);
    write_reg(REG_LEAD_SPACE, lead_space);
    write_reg(REG_BIT_MARK, bit_mark);
    write_reg(REG_ONE_SPACE, one_space);
    write_reg(REG_ZERO_SPACE, zero_space);
    write_reg(REG_ADDR_FIRST, addr_a);
    write_reg(REG_ADDR_SECOND, addr_b);
    write_reg(RegNone, 16'($urandom_range(0, 65535)));
    cfg_valid <= 1'b0;
  endtask

  // Stimulus sequence.
  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Default timing: ticks while idle, a start, starts while busy, then
    // a run of random items inside the leader.
    send_item(KIND_TICK, 8'hFF);
    send_item(KIND_TICK, 8'h00);
    send_item(KIND_START, 8'h00);
    send_item(KIND_START, 8'hFF);
    repeat (6) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
    send_item(KIND_START, 8'hA5);
    run_items(150);

    // Shortest lengths with extreme addresses; upper data bits must be dropped.
    load_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'h0000, 16'hFFFF);
    send_item(KIND_START, 8'hFF);
    run_items(50);

    // Zero lengths behave like one tick.
    load_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'h00FF, 16'hFF00);
    send_item(KIND_START, 8'h5A);
    run_items(50);

    // Longest lengths: the frame stalls in the leader until shorter values come.
    load_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    send_item(KIND_START, 8'($urandom_range(0, 255)));
    run_items(30);

    // Random short lengths, switched while frames may be running.
    repeat (4) begin
      load_timing(16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                  16'($urandom_range(0, 4)), 16'($urandom_range(0, 5)),
                  16'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                  16'($urandom_range(0, 65535)));
      run_items(25);
    end

    // Drain and give the verdict.
    do @(posedge clk); while (pending != 0);
    repeat (TailCycles) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
